// File: design/bcmf2d_pkg.sv
// Shared constants and controller/datapath interface types for the median filter.
package bcmf2d_pkg;

	localparam int PIX_W      = 8;
	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 1024;
	localparam int MAX_RADIUS = 3;
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int ROW_W      = $clog2(MAX_HEIGHT);
	localparam int DIM_W      = 11;
	localparam int RAD_W      = 2;
	localparam int LINE_ROWS  = 2 * MAX_RADIUS + 2;
	localparam int LROW_W     = $clog2(LINE_ROWS);
	localparam int LS_DEPTH   = LINE_ROWS * MAX_WIDTH;
	localparam int LS_ADDR_W  = LROW_W + COL_W;
	localparam int WIN_SIDE   = 2 * MAX_RADIUS + 1;
	localparam int WIN_N      = WIN_SIDE * WIN_SIDE;
	localparam int CNT_W      = $clog2(WIN_N + 1);
	localparam int CFG_IDX_W  = 2;

	// Register indexes on the config port
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 2'd2;

	// Controller -> datapath commands
	typedef struct packed {
		logic load_win;  // latch window bounds, clear sorter
		logic issue;     // issue one line store read
		logic shift;     // drop the smallest sorted sample
		logic emit;      // load output register, advance output position
	} cmd_t;

	// Datapath -> controller status
	typedef struct packed {
		logic out_ready;   // all samples for the next output are stored
		logic issue_last;  // current read is the last of the window
		logic shift_done;  // median sits at the head of the sorter
		logic out_free;    // output register is empty
	} sts_t;

endpackage

// File: design/bcmf2d_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bcmf2d_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: design/bcmf2d_ctrl.sv
// Controller: sequences store, window gather, median selection and output.
module bcmf2d_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_fire,
	output logic              in_ready,
	input  bcmf2d_pkg::sts_t  sts,
	output bcmf2d_pkg::cmd_t  cmd
);
	import bcmf2d_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_GATHER,
		S_DRAIN,
		S_SHIFT,
		S_EMIT
	} state_t;

	state_t state_q;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE:   if (in_fire) state_q <= S_CHECK;
				S_CHECK:  state_q <= sts.out_ready ? S_GATHER : S_IDLE;
				S_GATHER: if (sts.issue_last) state_q <= S_DRAIN;
				S_DRAIN:  state_q <= S_SHIFT;
				S_SHIFT:  if (sts.shift_done) state_q <= S_EMIT;
				S_EMIT:   if (sts.out_free) state_q <= S_IDLE;
				default:  state_q <= S_IDLE;
			endcase
		end
	end

	// Commands
	always_comb begin
		cmd          = '0;
		cmd.load_win = (state_q == S_CHECK) && sts.out_ready;
		cmd.issue    = (state_q == S_GATHER);
		cmd.shift    = (state_q == S_SHIFT) && !sts.shift_done;
		cmd.emit     = (state_q == S_EMIT) && sts.out_free;
	end

	assign in_ready = (state_q == S_IDLE);

endmodule

// File: design/bcmf2d_dp.sv
// Datapath: config, positions, line store, window gather, insertion sorter.
module bcmf2d_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [bcmf2d_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bcmf2d_pkg::DIM_W-1:0]      cfg_data,
	input  logic                              in_fire,
	input  logic                              in_mode,
	input  logic [bcmf2d_pkg::PIX_W-1:0]      in_pixel,
	input  bcmf2d_pkg::cmd_t                  cmd,
	output bcmf2d_pkg::sts_t                  sts,
	input  logic                              out_take,
	output logic                              out_valid,
	output logic [bcmf2d_pkg::PIX_W-1:0]      out_pixel,
	output logic                              out_last
);
	import bcmf2d_pkg::*;

	logic [DIM_W-1:0] width_q, height_q;
	logic [RAD_W-1:0] radius_q;
	logic [DIM_W-1:0] w_eff, h_eff;
	logic [COL_W-1:0] wm1;
	logic [ROW_W-1:0] hm1;
	logic [RAD_W-1:0] r_eff;

	logic [ROW_W:0]   in_row_q;
	logic [COL_W-1:0] in_col_q;
	logic [ROW_W-1:0] out_row_q;
	logic [COL_W-1:0] out_col_q;

	logic [ROW_W-1:0] r1_q, gy_q;
	logic [COL_W-1:0] c0_q, c1_q, gx_q;
	logic             rd_vld_s1;
	logic [PIX_W-1:0] rd_data;

	logic [PIX_W-1:0] sr_q [WIN_N];
	logic [CNT_W-1:0] cnt_q, sh_q, mid;
	logic             out_valid_q, out_last_q;
	logic [PIX_W-1:0] out_pixel_q;

	logic             pix_we, frame_last;
	logic [ROW_W:0]   row_hi;
	logic [COL_W:0]   col_hi;
	logic [ROW_W-1:0] nr;
	logic [COL_W-1:0] nc;
	logic [PIX_W:0]   pair_sum;

	// Effective geometry with out-of-range values clamped
	always_comb begin
		w_eff = (width_q == '0) ? DIM_W'(1) :
			(width_q > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : width_q;
		h_eff = (height_q == '0) ? DIM_W'(1) :
			(height_q > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : height_q;
		r_eff = (radius_q > RAD_W'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) : radius_q;
		wm1   = COL_W'(w_eff - DIM_W'(1));
		hm1   = ROW_W'(h_eff - DIM_W'(1));
	end

	// Last sample needed by the next output, compared against the input position
	always_comb begin
		row_hi = {1'b0, out_row_q} + (ROW_W+1)'(r_eff);
		col_hi = {1'b0, out_col_q} + (COL_W+1)'(r_eff);
		nr     = (row_hi > {1'b0, hm1}) ? hm1 : ROW_W'(row_hi);
		nc     = (col_hi > {1'b0, wm1}) ? wm1 : COL_W'(col_hi);
		sts.out_ready  = ({1'b0, nr} < in_row_q) ||
			(({1'b0, nr} == in_row_q) && (nc < in_col_q));
		sts.issue_last = (gy_q == r1_q) && (gx_q == c1_q);
		mid            = (cnt_q - CNT_W'(1)) >> 1;
		sts.shift_done = (sh_q == mid);
		sts.out_free   = !out_valid_q;
	end

	assign pix_we     = in_fire && !in_mode && (in_row_q < h_eff);
	assign frame_last = (out_row_q == hm1) && (out_col_q == wm1);

	// Config registers and raster positions
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q   <= DIM_W'(MAX_WIDTH);
			height_q  <= DIM_W'(MAX_HEIGHT);
			radius_q  <= RAD_W'(1);
			in_row_q  <= '0;
			in_col_q  <= '0;
			out_row_q <= '0;
			out_col_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_WIDTH:  width_q  <= cfg_data;
				REG_HEIGHT: height_q <= cfg_data;
				REG_RADIUS: radius_q <= cfg_data[RAD_W-1:0];
				default:    ;
			endcase
			if (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT ||
					cfg_index == REG_RADIUS) begin
				in_row_q  <= '0;
				in_col_q  <= '0;
				out_row_q <= '0;
				out_col_q <= '0;
			end
		end else begin
			if (pix_we) begin
				if (in_col_q == wm1) begin
					in_col_q <= '0;
					in_row_q <= in_row_q + (ROW_W+1)'(1);
				end else begin
					in_col_q <= in_col_q + COL_W'(1);
				end
			end
			if (cmd.emit) begin
				if (frame_last) begin
					in_row_q  <= '0;
					in_col_q  <= '0;
					out_row_q <= '0;
					out_col_q <= '0;
				end else if (out_col_q == wm1) begin
					out_col_q <= '0;
					out_row_q <= out_row_q + ROW_W'(1);
				end else begin
					out_col_q <= out_col_q + COL_W'(1);
				end
			end
		end
	end

	// Line store
	bcmf2d_ram #(
		.WIDTH(PIX_W),
		.DEPTH(LS_DEPTH)
	) u_line_store (
		.clk  (clk),
		.we   (pix_we),
		.waddr({in_row_q[LROW_W-1:0], in_col_q}),
		.wdata(in_pixel),
		.raddr({gy_q[LROW_W-1:0], gx_q}),
		.rdata(rd_data)
	);

	// Window bounds and read address walk
	always_ff @(posedge clk) begin
		if (cmd.load_win) begin
			c0_q <= (out_col_q >= COL_W'(r_eff)) ? out_col_q - COL_W'(r_eff) : '0;
			gy_q <= (out_row_q >= ROW_W'(r_eff)) ? out_row_q - ROW_W'(r_eff) : '0;
			gx_q <= (out_col_q >= COL_W'(r_eff)) ? out_col_q - COL_W'(r_eff) : '0;
			r1_q <= nr;
			c1_q <= nc;
		end else if (cmd.issue) begin
			if (gx_q == c1_q) begin
				gx_q <= c0_q;
				gy_q <= gy_q + ROW_W'(1);
			end else begin
				gx_q <= gx_q + COL_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1 <= 1'b0;
			cnt_q     <= '0;
			sh_q      <= '0;
		end else begin
			rd_vld_s1 <= cmd.issue;
			if (cmd.load_win) begin
				cnt_q <= '0;
				sh_q  <= '0;
			end else begin
				if (rd_vld_s1) cnt_q <= cnt_q + CNT_W'(1);
				if (cmd.shift) sh_q <= sh_q + CNT_W'(1);
			end
		end
	end

	// Insertion sorter: ascending, slots at or past the count act as empty
	always_ff @(posedge clk) begin
		for (int i = 0; i < WIN_N; i++) begin
			logic big_i, big_p;
			big_i = (CNT_W'(i) >= cnt_q) || (sr_q[i] > rd_data);
			big_p = (i > 0) && ((CNT_W'(i - 1) >= cnt_q) || (sr_q[(i > 0) ? i - 1 : 0] > rd_data));
			if (rd_vld_s1) begin
				if (big_i) sr_q[i] <= big_p ? sr_q[(i > 0) ? i - 1 : 0] : rd_data;
			end else if (cmd.shift && i < WIN_N - 1) begin
				sr_q[i] <= sr_q[(i < WIN_N - 1) ? i + 1 : i];
			end
		end
	end

	assign pair_sum = {1'b0, sr_q[0]} + {1'b0, sr_q[1]};

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_take) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_pixel_q <= cnt_q[0] ? sr_q[0] : pair_sum[PIX_W:1];
			out_last_q  <= frame_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_pixel = out_pixel_q;
	assign out_last  = out_last_q;

	// Checks
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(WIN_N))
		else $error("sorter count above window size");
	a_frame_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit && frame_last && !cfg_we |=> in_row_q == '0 && out_row_q == '0)
		else $error("positions not cleared at frame end");
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> !out_valid_q)
		else $error("output register overwritten");

endmodule

// File: design/border_cropped_median_filter_2d_top.sv
// Top level of the border-cropped 2-D median filter.
//
// Usage: pixels arrive in raster order on the s_axis word channel, tuser = 0
// for a pixel and 1 for a flush tick. Each accepted pixel word stores its pixel in
// the line store, then the block emits at most one filtered word on m_axis:
// the median of the window (side 2*radius+1) cropped to the image, with the
// floor of the mean of the two middle samples for an even count. tlast marks
// the final word of a frame. After the last pixel, flush words drain the
// remaining outputs one each.
// Timing: one word at a time; a new word is taken only once the result of the
// last one, if any, sits in the output register. A word that yields an output
// needs one line store read per sample of the cropped window (up to 49 samples)
// and one sorter step per sample and per discarded low value.
// Config writes (cfg_we) take effect at once and restart the frame; write
// them only while idle. Reset clears positions and loads width 1024,
// height 1024, radius 1. If the receiver stalls, the result holds in the
// output register; the next word is still taken, but its result waits.
module border_cropped_median_filter_2d_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [bcmf2d_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bcmf2d_pkg::DIM_W-1:0]      cfg_data,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [bcmf2d_pkg::PIX_W-1:0]      s_axis_tdata,  // [7:0] pixel_value
	input  logic                              s_axis_tuser,  // [0] mode
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [bcmf2d_pkg::PIX_W-1:0]      m_axis_tdata,  // [7:0] filtered_pixel
	output logic                              m_axis_tlast
);
	import bcmf2d_pkg::*;

	cmd_t cmd;
	sts_t sts;
	logic in_fire;

	assign in_fire = s_axis_tvalid && s_axis_tready;

	bcmf2d_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_fire (in_fire),
		.in_ready(s_axis_tready),
		.sts     (sts),
		.cmd     (cmd)
	);

	bcmf2d_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.in_fire  (in_fire),
		.in_mode  (s_axis_tuser),
		.in_pixel (s_axis_tdata),
		.cmd      (cmd),
		.sts      (sts),
		.out_take (m_axis_tready),
		.out_valid(m_axis_tvalid),
		.out_pixel(m_axis_tdata),
		.out_last (m_axis_tlast)
	);

endmodule

// File: test/tb_border_cropped_median_filter_2d_top.sv
// Self-checking testbench for the border-cropped 2-D median filter top level.
`timescale 1ns / 1ps

// Scoreboard of expected output words, in arrival order
class median_scoreboard;
	logic [7:0] exp_pix[$];
	logic       exp_last[$];
	int         errors;

	function new();
		errors = 0;
	endfunction

	// note the result (if any) caused by one accepted input word
	function void note_input(bit has_out, logic [7:0] pix, logic last);
		if (has_out) begin
			exp_pix.push_back(pix);
			exp_last.push_back(last);
		end
	endfunction

	function void check_output(logic [7:0] pix, logic last);
		logic [7:0] ep;
		logic       el;
		if (exp_pix.size() == 0) begin
			$error("unexpected output word filtered_pixel=%0d last_pixel=%0d", pix, last);
			errors++;
			return;
		end
		ep = exp_pix.pop_front();
		el = exp_last.pop_front();
		if (pix !== ep) begin
			$error("filtered_pixel mismatch: expected %0d actual %0d", ep, pix);
			errors++;
		end
		if (last !== el) begin
			$error("last_pixel mismatch: expected %0d actual %0d", el, last);
			errors++;
		end
	endfunction
endclass

module tb_border_cropped_median_filter_2d_top;
	import bcmf2d_pkg::*;

	localparam int CYCLE_LIMIT = 3000000;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [DIM_W-1:0]     cfg_data;
	logic                 s_axis_tvalid;
	logic                 s_axis_tready;
	logic [PIX_W-1:0]     s_axis_tdata;
	logic                 s_axis_tuser;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [PIX_W-1:0]     m_axis_tdata;
	logic                 m_axis_tlast;

	median_scoreboard sb;

	// predictor state
	logic [7:0]  pix_rows[LINE_ROWS][MAX_WIDTH];
	int unsigned cfg_w, cfg_h, cfg_r;
	int unsigned in_pos, out_pos;
	int unsigned cycles = 0;
	int unsigned out_wait = 0;
	bit          hold_off;
	bit          rand_stall;

	border_cropped_median_filter_2d_top i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	always #5 clk = ~clk;

	function automatic int unsigned eff_w();
		return (cfg_w == 0) ? 1 : (cfg_w > MAX_WIDTH ? MAX_WIDTH : cfg_w);
	endfunction

	function automatic int unsigned eff_h();
		return (cfg_h == 0) ? 1 : (cfg_h > MAX_HEIGHT ? MAX_HEIGHT : cfg_h);
	endfunction

	// cropped-window median for output index k
	function automatic logic [7:0] crop_median(int unsigned k);
		int unsigned w, h, ro, co, r0, r1, c0, c1, n, v, j;
		logic [7:0]  s[$];
		w = eff_w();
		h = eff_h();
		ro = k / w;
		co = k % w;
		r0 = (ro >= cfg_r) ? ro - cfg_r : 0;
		r1 = (ro + cfg_r > h - 1) ? h - 1 : ro + cfg_r;
		c0 = (co >= cfg_r) ? co - cfg_r : 0;
		c1 = (co + cfg_r > w - 1) ? w - 1 : co + cfg_r;
		for (int y = r0; y <= r1; y++)
			for (int x = c0; x <= c1; x++)
				s.push_back(pix_rows[y % LINE_ROWS][x]);
		s.sort();
		n = s.size();
		if (n % 2) return s[n / 2];
		v = (int'(s[n / 2 - 1]) + int'(s[n / 2])) / 2;
		j = v;
		return j[7:0];
	endfunction

	// advance the predictor by one accepted word
	function automatic void predict(logic mode, logic [7:0] pix);
		int unsigned w, h, total, nr, nc, k;
		logic [7:0]  med;
		logic        last;
		w = eff_w();
		h = eff_h();
		total = w * h;
		if (out_pos >= total || in_pos > total) begin
			in_pos = 0;
			out_pos = 0;
		end
		if (!mode && in_pos < total) begin
			pix_rows[(in_pos / w) % LINE_ROWS][in_pos % w] = pix;
			in_pos++;
		end
		k = out_pos;
		if (k >= total) begin
			sb.note_input(0, '0, 0);
			return;
		end
		nr = k / w + cfg_r;
		nc = k % w + cfg_r;
		if (nr > h - 1) nr = h - 1;
		if (nc > w - 1) nc = w - 1;
		if (nr * w + nc >= in_pos) begin
			sb.note_input(0, '0, 0);
			return;
		end
		med = crop_median(k);
		last = (k == total - 1);
		out_pos++;
		if (out_pos >= total) begin
			in_pos = 0;
			out_pos = 0;
		end
		sb.note_input(1, med, last);
	endfunction

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val[DIM_W-1:0];
		@(posedge clk);
		cfg_we    <= 1'b0;
		if (idx == REG_WIDTH) cfg_w = val;
		else if (idx == REG_HEIGHT) cfg_h = val;
		else cfg_r = val;
		in_pos = 0;
		out_pos = 0;
	endtask

	// wait for all results plus the longest output latency before reconfiguring
	task automatic drain_idle();
		s_axis_tvalid <= 1'b0;
		while (sb.exp_pix.size() != 0) @(posedge clk);
		repeat (120) @(posedge clk);
	endtask

	// valid stays high after acceptance until the next gap or idle point
	task automatic send_word(logic mode, logic [7:0] pix, bit gaps);
		int unsigned gap;
		gap = gaps ? $urandom_range(7, 0) : 0;
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= mode;
		s_axis_tdata  <= pix;
		do @(posedge clk); while (!s_axis_tready);
		predict(mode, pix);
	endtask

	// one frame of random pixels with random flush words mixed in, then flushes until the frame is done
	task automatic run_frame(bit gaps, int unsigned noise_pct);
		int unsigned total, guard;
		total = eff_w() * eff_h();
		for (int unsigned i = 0; i < total; i++) begin
			if ($urandom_range(99, 0) < noise_pct)
				send_word(1'b1, 8'($urandom), gaps);
			send_word(1'b0, 8'($urandom), gaps);
		end
		guard = 0;
		while (in_pos != 0 && guard < 4 * total + 8) begin
			send_word(1'b1, 8'($urandom), gaps);
			guard++;
		end
	endtask

	task automatic config_all(int unsigned w, int unsigned h, int unsigned r);
		drain_idle();
		write_reg(REG_WIDTH, w);
		write_reg(REG_HEIGHT, h);
		write_reg(REG_RADIUS, r);
	endtask

	// output side: random wait per word when rand_stall is set, with a long hold-off window driven elsewhere
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				sb.check_output(m_axis_tdata, m_axis_tlast);
				out_wait = rand_stall ? $urandom_range(7, 0) : 0;
			end else if (out_wait != 0) begin
				out_wait = out_wait - 1;
			end
			m_axis_tready <= !hold_off && (out_wait == 0);
		end
	end

	// cycle watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		int unsigned sent;
		arst_n = 0;
		cfg_we = 0;
		cfg_index = REG_WIDTH;
		cfg_data = '0;
		s_axis_tvalid = 0;
		s_axis_tdata = '0;
		s_axis_tuser = 0;
		hold_off = 0;
		rand_stall = 0;
		sb = new();
		cfg_w = 1024;
		cfg_h = 1024;
		cfg_r = 1;
		in_pos = 0;
		out_pos = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: 1x1 frame, extreme values, flush with nothing ready
		config_all(1, 1, 0);
		send_word(1'b1, 8'hFF, 0);
		send_word(1'b0, 8'hFF, 0);
		send_word(1'b0, 8'h00, 0);
		// 3x3 radius 3: whole-image windows, extra pixel after end
		config_all(3, 3, 3);
		for (int i = 0; i < 9; i++) send_word(1'b0, (i % 2) ? 8'hFF : 8'h00, 0);
		send_word(1'b0, 8'h55, 0);
		for (int i = 0; i < 12; i++) send_word(1'b1, 8'h00, 0);
		// abandon a frame mid-way with a config write
		config_all(4, 2, 1);
		send_word(1'b0, 8'h80, 0);
		send_word(1'b0, 8'h7F, 0);
		// out-of-range: width and height 0
		config_all(0, 0, 2);
		send_word(1'b0, 8'hAA, 0);

		// random phases over several settings
		sent = 0;
		rand_stall = 1;
		while (sent < 700) begin
			int unsigned w, h, r;
			case ($urandom_range(4, 0))
				0: begin w = 1; h = $urandom_range(12, 1); end
				1: begin w = $urandom_range(12, 1); h = 1; end
				2: begin w = 2047; h = 1; end
				default: begin w = $urandom_range(16, 1); h = $urandom_range(10, 1); end
			endcase
			if (w > MAX_WIDTH && h == 1) w = 1100;
			r = $urandom_range(3, 0);
			config_all(w, h, r);
			rand_stall = $urandom_range(1, 0);
			if (sent == 0) begin
				// long receiver hold-off while input keeps coming
				fork
					begin
						hold_off = 1;
						repeat (2000) @(posedge clk);
						hold_off = 0;
					end
					run_frame($urandom_range(1, 0), 5);
				join
			end else begin
				run_frame($urandom_range(1, 0), 5);
			end
			sent += eff_w() * eff_h();
		end
		// tall frame hitting the height limit with one column
		config_all(1, 2000, 3);
		run_frame(0, 0);
		s_axis_tvalid <= 1'b0;

		while (sb.exp_pix.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (sb.errors == 0) $display("Simulation PASSED");
		else $display("Simulation FAILED");
		$finish;
	end

endmodule
